/* rtl/clbs_pkg.sv */
// Shared types, codes and constants of the character LCD bus sequencer.
package clbs_pkg;

  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 30;
  localparam int unsigned WAIT_US_W = 22;
  localparam int unsigned SETTLE_W  = 16;

  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_CMD_WRITE   = 3'd1;
  localparam logic [2:0] OP_DATA_WRITE  = 3'd2;
  localparam logic [2:0] OP_READ_STATUS = 3'd3;
  localparam logic [2:0] OP_READ_DATA   = 3'd4;
  localparam logic [2:0] OP_GOTO        = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HIGH_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SETUP_TICKS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_SETTLE_US    = 2'd3;

  localparam logic [CFG_W-1:0] RST_TICKS_PER_US      = 8'd16;
  localparam logic [CFG_W-1:0] RST_ENABLE_HIGH_TICKS = 8'd8;
  localparam logic [CFG_W-1:0] RST_READ_SETUP_TICKS  = 8'd8;
  localparam logic [CFG_W-1:0] RST_BUSY_SETTLE_US    = 8'd8;

  localparam int unsigned      BUSY_BIT        = 7;
  localparam logic [7:0]       SET_ADDR_CMD    = 8'h80;
  localparam logic [7:0]       LINE_TWO_OFFSET = 8'h40;
  localparam logic [9:0]       MS_IN_US        = 10'd1000;

  typedef struct packed {
    logic [CFG_W-1:0]    ticks_per_us;
    logic [CFG_W-1:0]    enable_high_ticks;
    logic [CFG_W-1:0]    read_setup_ticks;
    logic [SETTLE_W-1:0] settle_ticks;
  } clbs_cfg_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [7:0]           data_byte;
    logic [5:0]           position;
    logic                 line_two;
    logic [WAIT_US_W-1:0] wait_us;
    logic [7:0]           bus_in;
  } clbs_item_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_not_write;
    logic       enable_pin;
    logic [7:0] bus_out;
    logic       bus_drive;
    logic       idle;
    logic       read_valid;
    logic [7:0] read_value;
    logic       rejected;
  } clbs_result_t;

endpackage

/* rtl/clbs_cfg_regs.sv */
// Configuration registers and the precomputed busy settle tick count.
module clbs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [clbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clbs_pkg::CFG_W-1:0]     cfg_data,
  output clbs_pkg::clbs_cfg_t            cfg
);
  import clbs_pkg::*;

  logic [CFG_W-1:0]    ticks_per_us;
  logic [CFG_W-1:0]    enable_high_ticks;
  logic [CFG_W-1:0]    read_setup_ticks;
  logic [CFG_W-1:0]    busy_settle_us;
  logic [SETTLE_W-1:0] settle_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us      <= RST_TICKS_PER_US;
      enable_high_ticks <= RST_ENABLE_HIGH_TICKS;
      read_setup_ticks  <= RST_READ_SETUP_TICKS;
      busy_settle_us    <= RST_BUSY_SETTLE_US;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TICKS_PER_US:      ticks_per_us      <= cfg_data;
        CFG_ENABLE_HIGH_TICKS: enable_high_ticks <= cfg_data;
        CFG_READ_SETUP_TICKS:  read_setup_ticks  <= cfg_data;
        CFG_BUSY_SETTLE_US:    busy_settle_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    settle_ticks <= SETTLE_W'(busy_settle_us) * SETTLE_W'(ticks_per_us);
  end

  assign cfg.ticks_per_us      = ticks_per_us;
  assign cfg.enable_high_ticks = enable_high_ticks;
  assign cfg.read_setup_ticks  = read_setup_ticks;
  assign cfg.settle_ticks      = settle_ticks;

endmodule

/* rtl/clbs_in_stage.sv */
// Input register: captures one beat and scales the wait to microseconds.
module clbs_in_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic [2:0]             op,
  input  logic [7:0]             data_byte,
  input  logic [5:0]             position,
  input  logic                   line_two,
  input  logic [11:0]            wait_count,
  input  logic                   wait_unit,
  input  logic [7:0]             bus_in,
  input  logic                   advance,
  output logic                   held_valid,
  output clbs_pkg::clbs_item_t   held_item
);
  import clbs_pkg::*;

  logic                 load;
  logic [WAIT_US_W-1:0] wait_us;

  assign item_stall = held_valid && !advance;
  assign load       = item_valid && !item_stall;
  assign wait_us    = wait_unit ? WAIT_US_W'(wait_count) * WAIT_US_W'(MS_IN_US)
                                : WAIT_US_W'(wait_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item.op        <= op;
      held_item.data_byte <= data_byte;
      held_item.position  <= position;
      held_item.line_two  <= line_two;
      held_item.wait_us   <= wait_us;
      held_item.bus_in    <= bus_in;
    end
  end

endmodule

/* rtl/clbs_seq.sv */
// Bus timing state machine, held request and registered result beat.
module clbs_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  clbs_pkg::clbs_cfg_t    cfg,
  input  logic                   held_valid,
  input  clbs_pkg::clbs_item_t   held_item,
  output logic                   advance,
  output logic                   result_valid,
  input  logic                   result_stall,
  output clbs_pkg::clbs_result_t result
);
  import clbs_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_POLL_HIGH, PH_POLL_LOW, PH_SETTLE,
    PH_WRITE_E, PH_WRITE_HOLD, PH_POST_WAIT, PH_READ_HIGH
  } phase_t;

  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     tick_counter, tick_counter_next;
  logic [7:0]           held_byte, held_byte_next;
  logic                 held_rs, held_rs_next;
  logic                 held_is_write, held_is_write_next;
  logic [WAIT_US_W-1:0] held_us, held_us_next;
  logic [CNT_W-1:0]     held_post_wait;
  logic [7:0]           last_read, last_read_next;
  logic                 request, rejected_next, read_valid_next, step;
  logic [7:0]           goto_addr;
  clbs_result_t         result_next;

  assign advance   = !result_valid || !result_stall;
  assign step      = held_valid && advance;
  assign request   = held_item.op >= OP_CMD_WRITE && held_item.op <= OP_GOTO;
  assign goto_addr = {2'b00, held_item.position} - 8'd1
                     + (held_item.line_two ? LINE_TWO_OFFSET : 8'd0);

  always_comb begin
    phase_next         = phase;
    tick_counter_next  = tick_counter;
    held_byte_next     = held_byte;
    held_rs_next       = held_rs;
    held_is_write_next = held_is_write;
    held_us_next       = held_us;
    last_read_next     = last_read;
    rejected_next      = 1'b0;
    read_valid_next    = 1'b0;
    if (phase == PH_IDLE) begin
      if (request) begin
        unique case (held_item.op)
          OP_CMD_WRITE, OP_DATA_WRITE: begin
            held_byte_next     = held_item.data_byte;
            held_rs_next       = held_item.op == OP_DATA_WRITE;
            held_is_write_next = 1'b1;
            held_us_next       = held_item.wait_us;
            phase_next         = PH_POLL_HIGH;
            tick_counter_next  = CNT_W'(cfg.read_setup_ticks);
          end
          OP_READ_STATUS, OP_READ_DATA: begin
            held_rs_next      = held_item.op == OP_READ_DATA;
            phase_next        = PH_READ_HIGH;
            tick_counter_next = CNT_W'(cfg.read_setup_ticks);
          end
          default: begin
            held_byte_next     = SET_ADDR_CMD | goto_addr;
            held_rs_next       = 1'b0;
            held_is_write_next = 1'b0;
            phase_next         = PH_WRITE_E;
            tick_counter_next  = CNT_W'(cfg.enable_high_ticks);
          end
        endcase
      end
    end else begin
      rejected_next = request;
      unique case (phase)
        PH_POLL_HIGH: begin
          if (tick_counter > CNT_W'(1)) begin
            tick_counter_next = tick_counter - CNT_W'(1);
          end else begin
            last_read_next = held_item.bus_in;
            if (held_item.bus_in[BUSY_BIT]) begin
              phase_next        = PH_POLL_LOW;
              tick_counter_next = '0;
            end else if (cfg.settle_ticks == '0) begin
              phase_next        = PH_WRITE_E;
              tick_counter_next = CNT_W'(cfg.enable_high_ticks);
            end else begin
              phase_next        = PH_SETTLE;
              tick_counter_next = CNT_W'(cfg.settle_ticks);
            end
          end
        end
        PH_POLL_LOW: begin
          phase_next        = PH_POLL_HIGH;
          tick_counter_next = CNT_W'(cfg.read_setup_ticks);
        end
        PH_SETTLE: begin
          if (tick_counter > CNT_W'(1)) begin
            tick_counter_next = tick_counter - CNT_W'(1);
          end else begin
            phase_next        = PH_WRITE_E;
            tick_counter_next = CNT_W'(cfg.enable_high_ticks);
          end
        end
        PH_WRITE_E: begin
          if (tick_counter > CNT_W'(1)) begin
            tick_counter_next = tick_counter - CNT_W'(1);
          end else begin
            phase_next        = PH_WRITE_HOLD;
            tick_counter_next = '0;
          end
        end
        PH_WRITE_HOLD: begin
          if (!held_is_write || held_post_wait == '0) begin
            phase_next        = PH_IDLE;
            tick_counter_next = '0;
          end else begin
            phase_next        = PH_POST_WAIT;
            tick_counter_next = held_post_wait;
          end
        end
        PH_POST_WAIT: begin
          if (tick_counter > CNT_W'(1)) begin
            tick_counter_next = tick_counter - CNT_W'(1);
          end else begin
            phase_next        = PH_IDLE;
            tick_counter_next = '0;
          end
        end
        PH_READ_HIGH: begin
          if (tick_counter > CNT_W'(1)) begin
            tick_counter_next = tick_counter - CNT_W'(1);
          end else begin
            last_read_next    = held_item.bus_in;
            read_valid_next   = 1'b1;
            phase_next        = PH_IDLE;
            tick_counter_next = '0;
          end
        end
        default: begin
          phase_next        = PH_IDLE;
          tick_counter_next = '0;
        end
      endcase
    end
  end

  always_comb begin
    result_next.reg_select     = 1'b0;
    result_next.read_not_write = 1'b0;
    result_next.enable_pin     = 1'b0;
    result_next.bus_drive      = 1'b1;
    unique case (phase_next)
      PH_POLL_HIGH: begin
        result_next.read_not_write = 1'b1;
        result_next.enable_pin     = 1'b1;
        result_next.bus_drive      = 1'b0;
      end
      PH_POLL_LOW: begin
        result_next.read_not_write = 1'b1;
        result_next.bus_drive      = 1'b0;
      end
      PH_WRITE_E: begin
        result_next.reg_select = held_rs_next;
        result_next.enable_pin = 1'b1;
      end
      PH_SETTLE, PH_WRITE_HOLD, PH_POST_WAIT: begin
        result_next.reg_select = held_rs_next;
      end
      PH_READ_HIGH: begin
        result_next.reg_select     = held_rs_next;
        result_next.read_not_write = 1'b1;
        result_next.enable_pin     = 1'b1;
        result_next.bus_drive      = 1'b0;
      end
      default: ;
    endcase
    result_next.bus_out    = result_next.bus_drive ? held_byte_next : 8'd0;
    result_next.idle       = phase_next == PH_IDLE;
    result_next.read_valid = read_valid_next;
    result_next.read_value = last_read_next;
    result_next.rejected   = rejected_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_counter  <= '0;
      held_byte     <= '0;
      held_rs       <= 1'b0;
      held_is_write <= 1'b0;
      held_us       <= '0;
      last_read     <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (step) begin
        phase         <= phase_next;
        tick_counter  <= tick_counter_next;
        held_byte     <= held_byte_next;
        held_rs       <= held_rs_next;
        held_is_write <= held_is_write_next;
        held_us       <= held_us_next;
        last_read     <= last_read_next;
      end
      if (advance) begin
        result_valid <= held_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    held_post_wait <= CNT_W'(held_us) * CNT_W'(cfg.ticks_per_us);
    if (step) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/char_lcd_bus_sequencer_unit.sv */
// Top level of the 8-bit character LCD bus sequencer.
//
// Each beat on the item channel is one tick of display bus time: it may carry
// a request (command or data write with busy polling, status or data read,
// cursor goto) and carries the level of the data lines for that tick. Each
// item yields exactly one beat on the result channel with the pin levels
// after that tick, the idle flag, the read strobe and value, and a flag for a
// request dropped because the sequencer was busy.
// The result beat is registered: the item passes the input register, then
// the state update into the result register. Throughput is one item per
// cycle while the result side does not stall; the poll, settle, strobe and
// post-write waits are counted in items.
// The post-write wait is scaled by a registered multiplier pair (a wait in
// milliseconds times 1000, then times ticks_per_us) and the settle time by a
// registered product of the settle and tick registers.
// A stall on the result side holds the result beat and the state; the input
// register still takes one beat and then stalls the item side.
// Reset sets the idle phase, clears the held byte and last read value and loads
// the register defaults. Registers are written by the user through cfg_write,
// cfg_index and cfg_data only while the block is idle; the block does not enforce this.
module char_lcd_bus_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [clbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clbs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [2:0]                     op,
  input  logic [7:0]                     data_byte,
  input  logic [5:0]                     position,
  input  logic                           line_two,
  input  logic [11:0]                    wait_count,
  input  logic                           wait_unit,
  input  logic [7:0]                     bus_in,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           reg_select,
  output logic                           read_not_write,
  output logic                           enable_pin,
  output logic                           chip_select,
  output logic [7:0]                     bus_out,
  output logic                           bus_drive,
  output logic                           idle,
  output logic                           read_valid,
  output logic [7:0]                     read_value,
  output logic                           rejected
);
  import clbs_pkg::*;

  clbs_cfg_t    cfg;
  clbs_item_t   held_item;
  clbs_result_t result;
  logic         held_valid;
  logic         advance;

  clbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clbs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .data_byte  (data_byte),
    .position   (position),
    .line_two   (line_two),
    .wait_count (wait_count),
    .wait_unit  (wait_unit),
    .bus_in     (bus_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  clbs_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .held_valid   (held_valid),
    .held_item    (held_item),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign reg_select     = result.reg_select;
  assign read_not_write = result.read_not_write;
  assign enable_pin     = result.enable_pin;
  assign chip_select    = 1'b1;
  assign bus_out        = result.bus_out;
  assign bus_drive      = result.bus_drive;
  assign idle           = result.idle;
  assign read_valid     = result.read_valid;
  assign read_value     = result.read_value;
  assign rejected       = result.rejected;

  a_read_ends_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && read_valid |-> idle)
    else $error("read strobe without return to idle");

  a_strobe_not_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && enable_pin |-> !idle)
    else $error("E high while idle");

  a_release_on_read: assert property (@(posedge clk) disable iff (rst)
    result_valid && !bus_drive |-> read_not_write && bus_out == 8'd0)
    else $error("bus released outside a read cycle");

endmodule
